### rtl/onewire_rom_search_macros.svh
// assertion macros shared by the checker of the 1-wire search core
`ifndef ONEWIRE_ROM_SEARCH_MACROS_SVH
`define ONEWIRE_ROM_SEARCH_MACROS_SVH

// property that must hold at every edge outside reset
`define OWS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define OWS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/ows_pkg.sv
// shared constants of the 1-wire search-rom decision core
package ows_pkg;

  // fixed field widths
  localparam int StatusW = 3;
  localparam int PosOutW = 6;

  // result status codes
  localparam logic [StatusW-1:0] StContinue = 3'd0;
  localparam logic [StatusW-1:0] StFound    = 3'd1;
  localparam logic [StatusW-1:0] StFinished = 3'd2;
  localparam logic [StatusW-1:0] StNoPres   = 3'd3;
  localparam logic [StatusW-1:0] StNoResp   = 3'd4;
  localparam logic [StatusW-1:0] StIgnored  = 3'd5;

  // request opcodes
  localparam logic OpStart = 1'b0;
  localparam logic OpPair  = 1'b1;

endpackage

### rtl/onewire_rom_search.sv
// 1-wire search-rom decision core: takes a start request or one received bit pair per
// request and answers with exactly one result (status, direction bit to write, the rom
// code built so far and the search position). Each request is captured in an input
// register and then decided into the result register, where it stays until taken;
// one request per cycle is sustained while the receiver takes every result. While a
// result waits to be taken one further request is held in the input register, after
// which the input stalls until the result is taken. A pass runs over CODE_BITS
// positions; after the last one the found code is reported with the device-found
// status and the fork record moves on to the next pass.
module onewire_rom_search #(
  parameter int CODE_BITS = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        opcode_i,
  input  logic                        restart_i,
  input  logic                        presence_i,
  input  logic                        id_bit_i,
  input  logic                        complement_bit_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [ows_pkg::StatusW-1:0] status_o,
  output logic                        write_bit_o,
  output logic [CODE_BITS-1:0]        rom_code_o,
  output logic [ows_pkg::PosOutW-1:0] bit_position_o
);
  import ows_pkg::*;

  localparam int PosW = $clog2(CODE_BITS);
  localparam logic [PosW-1:0] LastPos = PosW'(CODE_BITS - 1);

  // input stage
  logic s1_valid_q, s1_valid_d;
  logic s1_opcode_q, s1_restart_q, s1_presence_q, s1_id_q, s1_cmp_q;

  // search state
  logic [CODE_BITS-1:0] rom_q, rom_d;
  logic [PosW-1:0]      lf_q, lf_d;
  logic                 lfv_q, lfv_d;
  logic [PosW-1:0]      nf_q, nf_d;
  logic                 nfv_q, nfv_d;
  logic [PosW-1:0]      pos_q, pos_d;
  logic                 in_pass_q, in_pass_d;

  // result of the decision
  logic [StatusW-1:0]   res_status;
  logic                 res_wbit;
  logic [PosOutW-1:0]   res_pos;
  logic                 dir;

  logic out_valid_q;
  logic out_load;
  logic s1_fire;
  logic in_fire;

  // handshake control
  assign out_load   = !out_valid_q || out_ready_i;
  assign s1_fire    = s1_valid_q && out_load;
  assign in_ready_o = !s1_valid_q || out_load;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (s1_fire) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  // input payload register
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_opcode_q   <= opcode_i;
      s1_restart_q  <= restart_i;
      s1_presence_q <= presence_i;
      s1_id_q       <= id_bit_i;
      s1_cmp_q      <= complement_bit_i;
    end
  end

  // search decision for the captured request
  always_comb begin
    rom_d      = rom_q;
    lf_d       = lf_q;
    lfv_d      = lfv_q;
    nf_d       = nf_q;
    nfv_d      = nfv_q;
    pos_d      = pos_q;
    in_pass_d  = in_pass_q;
    res_status = StContinue;
    res_wbit   = 1'b0;
    res_pos    = PosOutW'(pos_q);
    dir        = 1'b0;

    if (s1_opcode_q == OpStart) begin
      res_pos   = '0;
      in_pass_d = 1'b0;
      if (s1_restart_q) begin
        rom_d = '0;
        lf_d  = '0;
        lfv_d = 1'b0;
      end
      if (!s1_restart_q && !lfv_q) begin
        res_status = StFinished;
      end else if (!s1_presence_q) begin
        res_status = StNoPres;
      end else begin
        in_pass_d = 1'b1;
        pos_d     = '0;
        nf_d      = '0;
        nfv_d     = 1'b0;
      end
    end else if (!in_pass_q) begin
      res_status = StIgnored;
    end else if (s1_id_q && s1_cmp_q) begin
      // nobody answered
      in_pass_d  = 1'b0;
      res_status = StNoResp;
    end else begin
      if (!s1_id_q && !s1_cmp_q) begin
        // fork: follow the record of the previous pass
        if (lfv_q && pos_q == lf_q) begin
          dir = 1'b1;
        end else if (!lfv_q || pos_q > lf_q) begin
          dir   = 1'b0;
          nf_d  = pos_q;
          nfv_d = 1'b1;
        end else begin
          dir = rom_q[pos_q];
          if (!dir) begin
            nf_d  = pos_q;
            nfv_d = 1'b1;
          end
        end
      end else begin
        dir = s1_id_q;
      end
      rom_d[pos_q] = dir;
      res_wbit     = dir;
      if (pos_q == LastPos) begin
        lf_d       = nf_d;
        lfv_d      = nfv_d;
        in_pass_d  = 1'b0;
        res_status = StFound;
      end else begin
        pos_d = pos_q + 1'b1;
      end
    end
  end

  // search state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rom_q     <= '0;
      lf_q      <= '0;
      lfv_q     <= 1'b0;
      nf_q      <= '0;
      nfv_q     <= 1'b0;
      pos_q     <= '0;
      in_pass_q <= 1'b0;
    end else if (s1_fire) begin
      rom_q     <= rom_d;
      lf_q      <= lf_d;
      lfv_q     <= lfv_d;
      nf_q      <= nf_d;
      nfv_q     <= nfv_d;
      pos_q     <= pos_d;
      in_pass_q <= in_pass_d;
    end
  end

  // result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= s1_valid_q;
    end
  end

  // result payload register
  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      status_o       <= res_status;
      write_bit_o    <= res_wbit;
      rom_code_o     <= rom_d;
      bit_position_o <= res_pos;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

### rtl/ows_checker.sv
// port-level checks of the 1-wire search core, bound to the top level
`include "onewire_rom_search_macros.svh"

module ows_checker #(
  parameter int CODE_BITS = 64
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [ows_pkg::StatusW-1:0] status_o,
  input logic                        write_bit_o,
  input logic [CODE_BITS-1:0]        rom_code_o,
  input logic [ows_pkg::PosOutW-1:0] bit_position_o
);
  import ows_pkg::*;

  logic stalled;
  logic found;
  logic wbit_ok;
  logic start_pos_ok;

  assign stalled      = out_valid_o && !out_ready_i;
  assign found        = out_valid_o && status_o == StFound;
  assign wbit_ok      = !write_bit_o || status_o == StContinue || status_o == StFound;
  assign start_pos_ok = (status_o != StFinished && status_o != StNoPres) ||
                        bit_position_o == '0;

  // status stays within the defined codes
  `OWS_ASSERT(a_status_range, !out_valid_o || status_o <= StIgnored, "status out of range")
  // direction bit only on a decided pair
  `OWS_ASSERT(a_wbit_decided, !out_valid_o || wbit_ok, "write bit set without a decision")
  // a found device is reported only at the last position
  `OWS_ASSERT(a_found_last, !found || bit_position_o == PosOutW'(CODE_BITS - 1),
              "device found before the last position")
  // finished and no-presence answers to start requests carry position zero
  `OWS_ASSERT(a_start_pos, !out_valid_o || start_pos_ok, "start answer with a position")
  // a stalled result holds its code
  `OWS_ASSERT_NEXT(a_stall_hold, stalled, out_valid_o && $stable(rom_code_o),
                   "stalled result changed")

endmodule

bind onewire_rom_search ows_checker #(.CODE_BITS(CODE_BITS)) u_ows_checker (.*);

### test/tb_top.sv
// self-checking testbench for the 1-wire search-rom decision core
module tb_top;
  import ows_pkg::*;

  localparam int CodeBits   = 64;
  localparam int CycleLimit = 400000;
  localparam int PhaseItems = 375;

  // one result as the core presents it
  typedef struct packed {
    logic [StatusW-1:0]  status;
    logic                write_bit;
    logic [CodeBits-1:0] rom_code;
    logic [PosOutW-1:0]  bit_position;
  } search_res_t;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  logic opcode_i;
  logic restart_i;
  logic presence_i;
  logic id_bit_i;
  logic complement_bit_i;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [StatusW-1:0]  status_o;
  logic                write_bit_o;
  logic [CodeBits-1:0] rom_code_o;
  logic [PosOutW-1:0]  bit_position_o;

  onewire_rom_search #(.CODE_BITS(CodeBits)) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .opcode_i         (opcode_i),
    .restart_i        (restart_i),
    .presence_i       (presence_i),
    .id_bit_i         (id_bit_i),
    .complement_bit_i (complement_bit_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .write_bit_o      (write_bit_o),
    .rom_code_o       (rom_code_o),
    .bit_position_o   (bit_position_o)
  );

  // predictor state of the search core
  logic [CodeBits-1:0] code_reg;
  logic [PosOutW-1:0]  fork_pos;
  logic                fork_ok;
  logic [PosOutW-1:0]  cand_pos;
  logic                cand_ok;
  logic [PosOutW-1:0]  search_pos;
  logic                pass_open;

  search_res_t expected_q[$];
  search_res_t last_res;
  search_res_t want_r;

  int send_idle_pct;
  int recv_stall_pct;
  int items_sent;
  int results_seen;
  int codes_found;
  int passes_aborted;
  int mismatch_cnt;
  int cycle_cnt;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // decision of the core for one accepted request
  function automatic search_res_t predict_search(input logic op, input logic rs,
                                                 input logic pr, input logic idb,
                                                 input logic cmp);
    search_res_t r;
    logic dir;
    r = '0;
    if (op == OpStart) begin
      pass_open = 1'b0;
      if (rs) begin
        code_reg = '0;
        fork_pos = '0;
        fork_ok  = 1'b0;
      end else if (!fork_ok) begin
        r.status   = StFinished;
        r.rom_code = code_reg;
        return r;
      end
      r.rom_code = code_reg;
      if (!pr) begin
        r.status = StNoPres;
        return r;
      end
      pass_open  = 1'b1;
      search_pos = '0;
      cand_pos   = '0;
      cand_ok    = 1'b0;
      r.status   = StContinue;
      return r;
    end
    r.bit_position = search_pos;
    r.rom_code     = code_reg;
    if (!pass_open) begin
      r.status = StIgnored;
      return r;
    end
    if (idb && cmp) begin
      pass_open = 1'b0;
      r.status  = StNoResp;
      return r;
    end
    // fork: both values present on the bus
    if (!idb && !cmp) begin
      if (fork_ok && search_pos == fork_pos) begin
        dir = 1'b1;
      end else if (!fork_ok || search_pos > fork_pos) begin
        dir      = 1'b0;
        cand_pos = search_pos;
        cand_ok  = 1'b1;
      end else begin
        dir = code_reg[search_pos];
        if (!dir) begin
          cand_pos = search_pos;
          cand_ok  = 1'b1;
        end
      end
    end else begin
      dir = idb;
    end
    code_reg[search_pos] = dir;
    r.write_bit = dir;
    r.rom_code  = code_reg;
    if (search_pos == CodeBits - 1) begin
      fork_pos  = cand_pos;
      fork_ok   = cand_ok;
      pass_open = 1'b0;
      r.status  = StFound;
    end else begin
      search_pos = search_pos + 1'b1;
      r.status   = StContinue;
    end
    return r;
  endfunction

  // present one request, wait for acceptance, queue its expected result
  task automatic send_req(input logic op, input logic rs, input logic pr,
                          input logic idb, input logic cmp);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    opcode_i         <= op;
    restart_i        <= rs;
    presence_i       <= pr;
    id_bit_i         <= idb;
    complement_bit_i <= cmp;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    last_res = predict_search(op, rs, pr, idb, cmp);
    expected_q.push_back(last_res);
    items_sent++;
  endtask

  task automatic drain_results();
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  // receiver back-pressure
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // result checking against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected result: status %0d write %0b code %h pos %0d",
                   status_o, write_bit_o, rom_code_o, bit_position_o);
      end else begin
        want_r = expected_q.pop_front();
        if (want_r.status == StFound) codes_found++;
        if (want_r.status == StNoResp) passes_aborted++;
        if (status_o !== want_r.status || write_bit_o !== want_r.write_bit ||
            rom_code_o !== want_r.rom_code || bit_position_o !== want_r.bit_position) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display("mismatch: exp status %0d write %0b code %h pos %0d",
                     want_r.status, want_r.write_bit, want_r.rom_code, want_r.bit_position);
            $display("          got status %0d write %0b code %h pos %0d",
                     status_o, write_bit_o, rom_code_o, bit_position_o);
          end
        end
      end
    end
  end

  // run-time guard
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("simulation failed");
      $finish;
    end
  end

  // starts and pairs while no pass is open
  task automatic test_idle_answers();
    send_req(OpStart, 1'b0, 1'b1, 1'b1, 1'b1);
    send_req(OpPair,  1'b1, 1'b1, 1'b1, 1'b1);
    send_req(OpStart, 1'b1, 1'b0, 1'b1, 1'b1);
    send_req(OpPair,  1'b0, 1'b0, 1'b0, 1'b0);
    send_req(OpStart, 1'b0, 1'b0, 1'b0, 1'b0);
  endtask

  // each kind of bit pair inside a pass, ending in an abort
  task automatic test_pair_kinds();
    send_req(OpStart, 1'b1, 1'b1, 1'b0, 1'b1);
    send_req(OpPair,  1'b0, 1'b0, 1'b1, 1'b0);
    send_req(OpPair,  1'b1, 1'b1, 1'b0, 1'b1);
    send_req(OpPair,  1'b0, 1'b1, 1'b0, 1'b0);
    send_req(OpPair,  1'b1, 1'b0, 1'b0, 1'b0);
    send_req(OpPair,  1'b0, 1'b0, 1'b1, 1'b1);
    send_req(OpPair,  1'b0, 1'b0, 1'b1, 1'b0);
    send_req(OpStart, 1'b0, 1'b1, 1'b0, 1'b0);
  endtask

  // a start that drops a running pass
  task automatic test_start_in_pass();
    send_req(OpStart, 1'b1, 1'b1, 1'b1, 1'b0);
    send_req(OpPair,  1'b0, 1'b0, 1'b1, 1'b0);
    send_req(OpPair,  1'b0, 1'b0, 1'b0, 1'b0);
    send_req(OpStart, 1'b1, 1'b1, 1'b0, 1'b1);
    send_req(OpPair,  1'b0, 1'b0, 1'b0, 1'b1);
    send_req(OpStart, 1'b1, 1'b0, 1'b0, 1'b0);
    send_req(OpPair,  1'b1, 1'b0, 1'b1, 1'b0);
  endtask

  // one enumeration run, of up to ten passes, over a random set of devices on the bus
  task automatic enumerate_bus(input int n_dev, input int stop_at);
    logic [CodeBits-1:0] devs [4];
    logic                alive [4];
    logic [CodeBits-1:0] base;
    logic                do_restart;
    logic                idb;
    logic                cmp;
    int                  cut;
    int                  flips;
    base = {$urandom, $urandom};
    case ($urandom_range(7))
      0: base = '0;
      1: base = '1;
      default: ;
    endcase
    for (int d = 0; d < 4; d++) begin
      devs[d] = base;
      flips = $urandom_range(1, 3);
      for (int f = 0; f < flips; f++)
        devs[d][$urandom_range(CodeBits - 1)] ^= 1'b1;
    end
    do_restart = 1'b1;
    for (int pass_n = 0; pass_n < 10; pass_n++) begin
      if (items_sent >= stop_at) break;
      // occasional noise ahead of the start
      if ($urandom_range(11) == 0)
        send_req(OpPair, 1'($urandom_range(1)), 1'($urandom_range(1)),
                 1'($urandom_range(1)), 1'($urandom_range(1)));
      if ($urandom_range(11) == 0)
        send_req(OpStart, 1'($urandom_range(1)), 1'b0,
                 1'($urandom_range(1)), 1'($urandom_range(1)));
      send_req(OpStart, do_restart, 1'b1, 1'($urandom_range(1)), 1'($urandom_range(1)));
      do_restart = ($urandom_range(29) == 0);
      if (last_res.status != StContinue) break;
      for (int d = 0; d < 4; d++) alive[d] = (d < n_dev);
      cut = ($urandom_range(9) == 0) ? $urandom_range(CodeBits - 1) : CodeBits;
      for (int p = 0; p < cut; p++) begin
        // wired-and of the two read slots over the devices still taking part
        idb = 1'b1;
        cmp = 1'b1;
        for (int d = 0; d < 4; d++) begin
          if (alive[d]) begin
            idb &= devs[d][p];
            cmp &= ~devs[d][p];
          end
        end
        if ($urandom_range(199) == 0) begin
          idb = 1'($urandom_range(1));
          cmp = 1'($urandom_range(1));
        end
        send_req(OpPair, 1'($urandom_range(1)), 1'($urandom_range(1)), idb, cmp);
        if (last_res.status != StContinue) break;
        for (int d = 0; d < 4; d++)
          if (devs[d][p] != last_res.write_bit) alive[d] = 1'b0;
      end
    end
  endtask

  // random enumerations under one idling mix
  task automatic test_enumeration(input int idle_pct, input int stall_pct);
    int target;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    target = items_sent + PhaseItems;
    while (items_sent < target)
      enumerate_bus(($urandom_range(9) == 0) ? 0 : $urandom_range(1, 4), target);
    in_valid_i <= 1'b0;
    drain_results();
  endtask

  initial begin
    rst_ni           <= 1'b0;
    in_valid_i       <= 1'b0;
    opcode_i         <= OpStart;
    restart_i        <= 1'b0;
    presence_i       <= 1'b0;
    id_bit_i         <= 1'b0;
    complement_bit_i <= 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    items_sent     = 0;
    results_seen   = 0;
    codes_found    = 0;
    passes_aborted = 0;
    mismatch_cnt   = 0;
    cycle_cnt      = 0;
    code_reg   = '0;
    fork_pos   = '0;
    fork_ok    = 1'b0;
    cand_pos   = '0;
    cand_ok    = 1'b0;
    search_pos = '0;
    pass_open  = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_idle_answers();
    test_pair_kinds();
    test_start_in_pass();
    in_valid_i <= 1'b0;
    drain_results();

    test_enumeration(0, 0);
    test_enumeration(64, 0);
    test_enumeration(0, 64);
    test_enumeration(34, 34);

    $display("%0d requests sent, %0d results checked over four idling mixes",
             items_sent, results_seen);
    $display("%0d rom codes found, %0d passes aborted, %0d mismatches",
             codes_found, passes_aborted, mismatch_cnt);
    if (mismatch_cnt == 0 && expected_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
